/* design/point_rotate_about_pivot_core_defines.svh */
// Assertion macros used by the checker file of the point rotation block.
`ifndef POINT_ROTATE_ABOUT_PIVOT_CORE_DEFINES_SVH
`define POINT_ROTATE_ABOUT_PIVOT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRAP_ASSERT_IMPL(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("point rotation check failed");

// Implication with a fixed delay in cycles, disabled while reset is asserted.
`define PRAP_ASSERT_DELAY(name, ck, rn, ante, dly, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##dly (cons)) \
        else $error("point rotation check failed");

`endif

/* design/prap_pkg.sv */
package prap_pkg;

    // Width of the angle port and of the angle inside the CORDIC chain.
    localparam int ANGLE_W = 26;
    localparam int ZW      = 27;
    // Width of the CORDIC x and y accumulators (Q30 with headroom).
    localparam int XW      = 34;
    localparam int ATAN_ENTRIES = 24;

    typedef logic signed [ZW-1:0] angle_t;
    typedef logic signed [XW-1:0] trig_acc_t;

    // Angles in 1/65536 degree.
    localparam angle_t HALF_TURN    = angle_t'(11796480);
    localparam angle_t FULL_TURN    = angle_t'(23592960);
    localparam angle_t QUARTER_TURN = angle_t'(5898240);

    // CORDIC gain compensation, 0.60725293 in Q30.
    localparam trig_acc_t CORDIC_K = trig_acc_t'(652032874);

    typedef enum logic [1:0] {
        OP_ROT_X = 2'd0,
        OP_ROT_Y = 2'd1,
        OP_ROT_Z = 2'd2,
        OP_PASS  = 2'd3
    } opcode_t;

    // Control that travels alongside each item.
    typedef struct packed {
        logic    valid;
        opcode_t op;
        logic    neg;
    } ctrl_t;

    // CORDIC working state of one item.
    typedef struct packed {
        trig_acc_t x;
        trig_acc_t y;
        angle_t    z;
    } cordic_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest.
    function automatic angle_t atan_lookup(input logic [4:0] idx);
        angle_t v;
        case (idx)
            5'd0:    v = angle_t'(2949120);
            5'd1:    v = angle_t'(1740967);
            5'd2:    v = angle_t'(919879);
            5'd3:    v = angle_t'(466945);
            5'd4:    v = angle_t'(234379);
            5'd5:    v = angle_t'(117304);
            5'd6:    v = angle_t'(58666);
            5'd7:    v = angle_t'(29335);
            5'd8:    v = angle_t'(14668);
            5'd9:    v = angle_t'(7334);
            5'd10:   v = angle_t'(3667);
            5'd11:   v = angle_t'(1833);
            5'd12:   v = angle_t'(917);
            5'd13:   v = angle_t'(458);
            5'd14:   v = angle_t'(229);
            5'd15:   v = angle_t'(115);
            5'd16:   v = angle_t'(57);
            5'd17:   v = angle_t'(29);
            5'd18:   v = angle_t'(14);
            5'd19:   v = angle_t'(7);
            5'd20:   v = angle_t'(4);
            5'd21:   v = angle_t'(2);
            5'd22:   v = angle_t'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/prap_front.sv */
module prap_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [1:0]                           opcode,
    input  logic signed [COORD_WIDTH-1:0]        point_x,
    input  logic signed [COORD_WIDTH-1:0]        point_y,
    input  logic signed [COORD_WIDTH-1:0]        point_z,
    input  logic signed [COORD_WIDTH-1:0]        pivot_x,
    input  logic signed [COORD_WIDTH-1:0]        pivot_y,
    input  logic signed [COORD_WIDTH-1:0]        pivot_z,
    input  logic signed [prap_pkg::ANGLE_W-1:0]  angle,
    output prap_pkg::ctrl_t                      ctrl_out,
    output prap_pkg::cordic_t                    cordic_out,
    output logic [5*COORD_WIDTH+1:0]             data_out
);
    import prap_pkg::*;

    localparam int DATA_W = 5 * COORD_WIDTH + 2;

    angle_t                       ang_ext;
    angle_t                       ang_wrap;
    angle_t                       ang_red;
    logic                         neg;
    logic signed [COORD_WIDTH-1:0] sel_a;
    logic signed [COORD_WIDTH-1:0] sel_b;
    logic signed [COORD_WIDTH-1:0] sel_pa;
    logic signed [COORD_WIDTH-1:0] sel_pb;
    logic signed [COORD_WIDTH-1:0] sel_pc;
    logic signed [COORD_WIDTH:0]   diff_a;
    logic signed [COORD_WIDTH:0]   diff_b;
    ctrl_t                        ctrl_next;
    ctrl_t                        ctrl_reg;
    cordic_t                      cordic_next;
    cordic_t                      cordic_reg;
    logic [DATA_W-1:0]            data_next;
    logic [DATA_W-1:0]            data_reg;

    // Angle reduction: wrap into one turn, then fold into plus or minus a quarter turn.
    always_comb
    begin
        ang_ext = angle_t'(angle);
        if (ang_ext >= HALF_TURN)
        begin
            ang_wrap = ang_ext - FULL_TURN;
        end
        else if (ang_ext < -HALF_TURN)
        begin
            ang_wrap = ang_ext + FULL_TURN;
        end
        else
        begin
            ang_wrap = ang_ext;
        end

        if (ang_wrap > QUARTER_TURN)
        begin
            ang_red = ang_wrap - HALF_TURN;
            neg     = 1'b1;
        end
        else if (ang_wrap < -QUARTER_TURN)
        begin
            ang_red = ang_wrap + HALF_TURN;
            neg     = 1'b1;
        end
        else
        begin
            ang_red = ang_wrap;
            neg     = 1'b0;
        end
    end

    // Pick the in-plane pair and the coordinate along the axis.
    always_comb
    begin
        case (opcode_t'(opcode))
            OP_ROT_X:
            begin
                sel_a  = point_y;
                sel_b  = point_z;
                sel_pa = pivot_y;
                sel_pb = pivot_z;
                sel_pc = point_x;
            end
            OP_ROT_Y:
            begin
                sel_a  = point_z;
                sel_b  = point_x;
                sel_pa = pivot_z;
                sel_pb = pivot_x;
                sel_pc = point_y;
            end
            default:
            begin
                // Rotation about Z; the pass-through code uses the same pair
                // with a unit rotation further down.
                sel_a  = point_x;
                sel_b  = point_y;
                sel_pa = pivot_x;
                sel_pb = pivot_y;
                sel_pc = point_z;
            end
        endcase

        diff_a = {sel_a[COORD_WIDTH-1], sel_a} - {sel_pa[COORD_WIDTH-1], sel_pa};
        diff_b = {sel_b[COORD_WIDTH-1], sel_b} - {sel_pb[COORD_WIDTH-1], sel_pb};

        ctrl_next.valid = accept;
        ctrl_next.op    = opcode_t'(opcode);
        ctrl_next.neg   = neg;

        cordic_next.x = CORDIC_K;
        cordic_next.y = '0;
        cordic_next.z = ang_red;

        data_next = {diff_a, diff_b, sel_pa, sel_pb, sel_pc};
    end

    // Entry registers of the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cordic_reg <= cordic_next;
        data_reg   <= data_next;
    end

    assign ctrl_out   = ctrl_reg;
    assign cordic_out = cordic_reg;
    assign data_out   = data_reg;

endmodule

/* design/prap_cell.sv */
module prap_cell #(
    parameter int DATA_W = 162,
    parameter int SHIFT  = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prap_pkg::ctrl_t   ctrl_in,
    input  prap_pkg::cordic_t cordic_in,
    input  logic [DATA_W-1:0] data_in,
    output prap_pkg::ctrl_t   ctrl_out,
    output prap_pkg::cordic_t cordic_out,
    output logic [DATA_W-1:0] data_out
);
    import prap_pkg::*;

    trig_acc_t         x_in;
    trig_acc_t         y_in;
    angle_t            z_in;
    trig_acc_t         dx;
    trig_acc_t         dy;
    angle_t            step;
    cordic_t           cordic_next;
    ctrl_t             ctrl_reg;
    cordic_t           cordic_reg;
    logic [DATA_W-1:0] data_reg;

    // One CORDIC micro-rotation; the direction follows the sign of the residual angle.
    always_comb
    begin
        x_in = cordic_in.x;
        y_in = cordic_in.y;
        z_in = cordic_in.z;
        dx   = y_in >>> SHIFT;
        dy   = x_in >>> SHIFT;
        step = atan_lookup(5'(SHIFT));
        if (!z_in[ZW-1])
        begin
            cordic_next.x = x_in - dx;
            cordic_next.y = y_in + dy;
            cordic_next.z = z_in - step;
        end
        else
        begin
            cordic_next.x = x_in + dx;
            cordic_next.y = y_in - dy;
            cordic_next.z = z_in + step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // The item's payload moves along with its CORDIC state.
    always_ff @(posedge clk)
    begin
        cordic_reg <= cordic_next;
        data_reg   <= data_in;
    end

    assign ctrl_out   = ctrl_reg;
    assign cordic_out = cordic_reg;
    assign data_out   = data_reg;

endmodule

/* design/prap_rotate.sv */
module prap_rotate #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prap_pkg::ctrl_t               ctrl_in,
    input  prap_pkg::cordic_t             cordic_in,
    input  logic [5*COORD_WIDTH+1:0]      data_in,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z,
    output logic                          overflow
);
    import prap_pkg::*;

    localparam int CW         = COORD_WIDTH;
    localparam int DATA_W     = 5 * CW + 2;
    localparam int PIV_W      = 3 * CW;
    localparam int TRIG_FRAC  = ((61 - CW) < 30) ? (61 - CW) : 30;
    localparam int TRIG_SHIFT = 30 - TRIG_FRAC;
    localparam int TW         = TRIG_FRAC + 2;
    localparam int DW         = CW + 1;
    localparam int PW         = TW + DW;
    localparam int SW         = PW + 1;
    localparam int QW         = SW - TRIG_FRAC;
    localparam int RW         = QW + 1;

    localparam trig_acc_t TRIG_RND =
        (TRIG_SHIFT == 0) ? trig_acc_t'(0) : trig_acc_t'(longint'(1) << (TRIG_SHIFT - 1));
    localparam trig_acc_t TRIG_LIM = trig_acc_t'(longint'(1) << TRIG_FRAC);
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(longint'(1) << (TRIG_FRAC - 1));
    localparam logic signed [RW-1:0] SAT_HI = RW'((longint'(1) << (CW - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    // Round a Q30 value to the trig format and clamp it to plus or minus one.
    function automatic logic signed [TW-1:0] round_trig(input trig_acc_t v);
        trig_acc_t r;
        r = (v + TRIG_RND) >>> TRIG_SHIFT;
        if (r > TRIG_LIM)
        begin
            r = TRIG_LIM;
        end
        else if (r < -TRIG_LIM)
        begin
            r = -TRIG_LIM;
        end
        return TW'(r);
    endfunction

    ctrl_t                  ctrl1_reg;
    ctrl_t                  ctrl2_reg;
    ctrl_t                  ctrl3_reg;
    ctrl_t                  ctrl4_reg;
    trig_acc_t              x_in;
    trig_acc_t              y_in;
    trig_acc_t              xn_next;
    trig_acc_t              yn_next;
    trig_acc_t              xn_reg;
    trig_acc_t              yn_reg;
    logic [DATA_W-1:0]      data1_reg;
    logic [DATA_W-1:0]      data2_reg;
    logic signed [TW-1:0]   cos_next;
    logic signed [TW-1:0]   sin_next;
    logic signed [TW-1:0]   cos_reg;
    logic signed [TW-1:0]   sin_reg;
    logic signed [DW-1:0]   diff_a;
    logic signed [DW-1:0]   diff_b;
    logic signed [PW-1:0]   prod_ca_reg;
    logic signed [PW-1:0]   prod_sb_reg;
    logic signed [PW-1:0]   prod_sa_reg;
    logic signed [PW-1:0]   prod_cb_reg;
    logic [PIV_W-1:0]       piv3_reg;
    logic [PIV_W-1:0]       piv4_reg;
    logic signed [SW-1:0]   sum_a;
    logic signed [SW-1:0]   sum_b;
    logic signed [QW-1:0]   qa_next;
    logic signed [QW-1:0]   qb_next;
    logic signed [QW-1:0]   qa_reg;
    logic signed [QW-1:0]   qb_reg;
    logic signed [CW-1:0]   piv_a;
    logic signed [CW-1:0]   piv_b;
    logic signed [CW-1:0]   keep_c;
    logic signed [RW-1:0]   res_a;
    logic signed [RW-1:0]   res_b;
    logic signed [CW-1:0]   sat_a;
    logic signed [CW-1:0]   sat_b;
    logic                   ovf_a;
    logic                   ovf_b;
    logic signed [CW-1:0]   rx_next;
    logic signed [CW-1:0]   ry_next;
    logic signed [CW-1:0]   rz_next;
    logic signed [CW-1:0]   rx_reg;
    logic signed [CW-1:0]   ry_reg;
    logic signed [CW-1:0]   rz_reg;
    logic                   ovf_reg;
    logic                   done_reg;

    // Undo the half-turn fold by negating both outputs of the chain.
    always_comb
    begin
        x_in = cordic_in.x;
        y_in = cordic_in.y;
        if (ctrl_in.neg)
        begin
            xn_next = -x_in;
            yn_next = -y_in;
        end
        else
        begin
            xn_next = x_in;
            yn_next = y_in;
        end
    end

    // Cosine and sine in the trig format; the pass-through code rotates by nothing.
    always_comb
    begin
        if (ctrl1_reg.op == OP_PASS)
        begin
            cos_next = TW'(TRIG_LIM);
            sin_next = '0;
        end
        else
        begin
            cos_next = round_trig(xn_reg);
            sin_next = round_trig(yn_reg);
        end
    end

    // Rounded rotation sums.
    always_comb
    begin
        diff_a  = data2_reg[DATA_W-1 -: DW];
        diff_b  = data2_reg[DATA_W-DW-1 -: DW];
        sum_a   = SW'(prod_ca_reg) - SW'(prod_sb_reg) + ROUND_HALF;
        sum_b   = SW'(prod_sa_reg) + SW'(prod_cb_reg) + ROUND_HALF;
        qa_next = QW'(sum_a >>> TRIG_FRAC);
        qb_next = QW'(sum_b >>> TRIG_FRAC);
    end

    // Add the pivot back, saturate, and put the coordinates back in their places.
    always_comb
    begin
        piv_a  = piv4_reg[PIV_W-1 -: CW];
        piv_b  = piv4_reg[PIV_W-CW-1 -: CW];
        keep_c = piv4_reg[CW-1:0];
        res_a  = RW'(qa_reg) + RW'(piv_a);
        res_b  = RW'(qb_reg) + RW'(piv_b);

        ovf_a = 1'b0;
        if (res_a > SAT_HI)
        begin
            sat_a = CW'(SAT_HI);
            ovf_a = 1'b1;
        end
        else if (res_a < SAT_LO)
        begin
            sat_a = CW'(SAT_LO);
            ovf_a = 1'b1;
        end
        else
        begin
            sat_a = CW'(res_a);
        end

        ovf_b = 1'b0;
        if (res_b > SAT_HI)
        begin
            sat_b = CW'(SAT_HI);
            ovf_b = 1'b1;
        end
        else if (res_b < SAT_LO)
        begin
            sat_b = CW'(SAT_LO);
            ovf_b = 1'b1;
        end
        else
        begin
            sat_b = CW'(res_b);
        end

        case (ctrl4_reg.op)
            OP_ROT_X:
            begin
                rx_next = keep_c;
                ry_next = sat_a;
                rz_next = sat_b;
            end
            OP_ROT_Y:
            begin
                rx_next = sat_b;
                ry_next = keep_c;
                rz_next = sat_a;
            end
            default:
            begin
                rx_next = sat_a;
                ry_next = sat_b;
                rz_next = keep_c;
            end
        endcase
    end

    // Control along the back-end stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctrl1_reg <= ctrl_in;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl2_reg;
            ctrl4_reg <= ctrl3_reg;
            done_reg  <= ctrl4_reg.valid;
        end
    end

    // Datapath registers: negate, trig, multiply, sum, result.
    always_ff @(posedge clk)
    begin
        xn_reg      <= xn_next;
        yn_reg      <= yn_next;
        data1_reg   <= data_in;
        cos_reg     <= cos_next;
        sin_reg     <= sin_next;
        data2_reg   <= data1_reg;
        prod_ca_reg <= PW'(cos_reg) * PW'(diff_a);
        prod_sb_reg <= PW'(sin_reg) * PW'(diff_b);
        prod_sa_reg <= PW'(sin_reg) * PW'(diff_a);
        prod_cb_reg <= PW'(cos_reg) * PW'(diff_b);
        piv3_reg    <= data2_reg[PIV_W-1:0];
        qa_reg      <= qa_next;
        qb_reg      <= qb_next;
        piv4_reg    <= piv3_reg;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        rz_reg      <= rz_next;
        ovf_reg     <= ovf_a | ovf_b;
    end

    assign done      = done_reg;
    assign rotated_x = rx_reg;
    assign rotated_y = ry_reg;
    assign rotated_z = rz_reg;
    assign overflow  = ovf_reg;

endmodule

/* design/point_rotate_about_pivot_core.sv */
// Rotates a 3D point about a pivot, around a line through the pivot parallel
// to the X, Y or Z axis chosen by opcode; the fourth opcode passes the point.
// Input channel: an item is taken at a rising edge where start is high and
// busy is low. Busy stays low, so a new item can enter on every clock cycle.
// Result channel: done is high for exactly one cycle with rotated_x/y/z and
// overflow; the receiver cannot stall, so results are never held back.
// From the accepting edge to the done cycle, an item passes one entry stage
// for angle reduction and pivot subtraction, one cell per CORDIC stage, then
// negate, trig rounding, multiply, sum and saturation stages.
// Throughput is one item per cycle, set by the fully pipelined chain of cells.
// Reset clears every valid bit in the pipeline; items in flight are dropped
// and no done pulse follows reset on its own.
module point_rotate_about_pivot_core #(
    parameter int COORD_WIDTH  = 32,
    parameter int ANGLE_STAGES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          opcode,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    input  logic signed [COORD_WIDTH-1:0]       pivot_x,
    input  logic signed [COORD_WIDTH-1:0]       pivot_y,
    input  logic signed [COORD_WIDTH-1:0]       pivot_z,
    input  logic signed [prap_pkg::ANGLE_W-1:0] angle,
    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       rotated_x,
    output logic signed [COORD_WIDTH-1:0]       rotated_y,
    output logic signed [COORD_WIDTH-1:0]       rotated_z,
    output logic                                overflow
);
    import prap_pkg::*;

    localparam int DATA_W = 5 * COORD_WIDTH + 2;

    ctrl_t             ctrl_chain   [ANGLE_STAGES+1];
    cordic_t           cordic_chain [ANGLE_STAGES+1];
    logic [DATA_W-1:0] data_chain   [ANGLE_STAGES+1];

    // The pipeline never stalls, so items are always taken.
    assign busy = 1'b0;

    prap_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (start && !busy),
        .opcode     (opcode),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .pivot_x    (pivot_x),
        .pivot_y    (pivot_y),
        .pivot_z    (pivot_z),
        .angle      (angle),
        .ctrl_out   (ctrl_chain[0]),
        .cordic_out (cordic_chain[0]),
        .data_out   (data_chain[0])
    );

    // Row of CORDIC cells, one micro-rotation each.
    for (genvar g = 0; g < ANGLE_STAGES; g++)
    begin : g_cell
        prap_cell #(
            .DATA_W (DATA_W),
            .SHIFT  (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl_in    (ctrl_chain[g]),
            .cordic_in  (cordic_chain[g]),
            .data_in    (data_chain[g]),
            .ctrl_out   (ctrl_chain[g+1]),
            .cordic_out (cordic_chain[g+1]),
            .data_out   (data_chain[g+1])
        );
    end

    prap_rotate #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (ctrl_chain[ANGLE_STAGES]),
        .cordic_in (cordic_chain[ANGLE_STAGES]),
        .data_in   (data_chain[ANGLE_STAGES]),
        .done      (done),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .rotated_z (rotated_z),
        .overflow  (overflow)
    );

endmodule

/* design/prap_checker.sv */
`include "point_rotate_about_pivot_core_defines.svh"

module prap_checker #(
    parameter int COORD_WIDTH  = 32,
    parameter int ANGLE_STAGES = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [1:0]                          opcode,
    input logic signed [COORD_WIDTH-1:0]       point_x,
    input logic signed [COORD_WIDTH-1:0]       point_y,
    input logic signed [COORD_WIDTH-1:0]       point_z,
    input logic signed [COORD_WIDTH-1:0]       pivot_x,
    input logic signed [COORD_WIDTH-1:0]       pivot_y,
    input logic signed [COORD_WIDTH-1:0]       pivot_z,
    input logic                                done,
    input logic signed [COORD_WIDTH-1:0]       rotated_x,
    input logic signed [COORD_WIDTH-1:0]       rotated_y,
    input logic signed [COORD_WIDTH-1:0]       rotated_z,
    input logic                                overflow
);
    import prap_pkg::*;

    localparam int LAT = ANGLE_STAGES + 6;

    // Every result belongs to an item taken a fixed latency earlier.
    `PRAP_ASSERT_IMPL(a_done_has_item, clk, rst_n, done, $past(start && !busy, LAT))

    // Every item taken gives a result after the fixed latency.
    `PRAP_ASSERT_DELAY(a_item_gives_done, clk, rst_n, start && !busy, LAT, done)

    // The spare opcode returns the point untouched and never saturates.
    `PRAP_ASSERT_DELAY(a_pass_unchanged, clk, rst_n, start && !busy && opcode == OP_PASS, LAT, rotated_x == $past(point_x, LAT) && rotated_y == $past(point_y, LAT) && rotated_z == $past(point_z, LAT) && !overflow)

    // A point sitting on the pivot stays there, whatever the angle.
    `PRAP_ASSERT_DELAY(a_pivot_fixed, clk, rst_n, start && !busy && point_x == pivot_x && point_y == pivot_y && point_z == pivot_z, LAT, rotated_x == $past(pivot_x, LAT) && rotated_y == $past(pivot_y, LAT) && rotated_z == $past(pivot_z, LAT) && !overflow)

endmodule

bind point_rotate_about_pivot_core prap_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .ANGLE_STAGES (ANGLE_STAGES)
) u_prap_checker (.*);

/* tb/point_rotate_about_pivot_core_tb.sv */
module point_rotate_about_pivot_core_tb;

    import prap_pkg::*;

    localparam int CW           = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int CLK_PERIOD   = 8;
    // Accepting edge to the end of the done cycle.
    localparam int LATENCY      = CORDIC_STEPS + 6;
    localparam int TRIG_FRAC    = ((61 - CW) < 30) ? (61 - CW) : 30;

    // Angle constants in 1/65536 degree.
    localparam longint DEG       = 65536;
    localparam longint HALF_REV  = 180 * DEG;
    localparam longint FULL_REV  = 360 * DEG;
    localparam longint RIGHT_ANG = 90 * DEG;
    localparam longint GAIN_Q30  = 652032874;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE_Q16   = 32'sd65536;

    // Arctangent of 2^-i in 1/65536 degree.
    localparam longint ARCTAN_DEG [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 ovf;
    } rot_result_t;

    logic                 clk;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    opcode_t              opcode  = OP_ROT_X;
    logic signed [CW-1:0] point_x = '0;
    logic signed [CW-1:0] point_y = '0;
    logic signed [CW-1:0] point_z = '0;
    logic signed [CW-1:0] pivot_x = '0;
    logic signed [CW-1:0] pivot_y = '0;
    logic signed [CW-1:0] pivot_z = '0;
    logic signed [ANGLE_W-1:0] angle = '0;
    logic                 done;
    logic signed [CW-1:0] rotated_x;
    logic signed [CW-1:0] rotated_y;
    logic signed [CW-1:0] rotated_z;
    logic                 overflow;

    rot_result_t pending_rotations [$];
    int          mismatch_count = 0;

    point_rotate_about_pivot_core #(
        .COORD_WIDTH  (CW),
        .ANGLE_STAGES (CORDIC_STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .pivot_x   (pivot_x),
        .pivot_y   (pivot_y),
        .pivot_z   (pivot_z),
        .angle     (angle),
        .done      (done),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .rotated_z (rotated_z),
        .overflow  (overflow)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block never delivers.
    initial
    begin
        #(CLK_PERIOD * 400000);
        $display("end of test: mismatches");
        $finish;
    end

    // Rounds a Q30 trig value to the working precision and clamps it to plus or minus one.
    function automatic longint round_trig(longint q30);
        longint v;
        longint lim;
        lim = longint'(1) << TRIG_FRAC;
        v = q30;
        if (TRIG_FRAC < 30)
            v = (q30 + (longint'(1) << (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC);
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v;
    endfunction

    // Clamps a wide coordinate to the port width and notes any clipping.
    function automatic longint clamp_coord(longint v, inout bit clipped);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            clipped = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clipped = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Expected outcome of rotating one point about its pivot.
    function automatic rot_result_t predict_rotation(
        opcode_t op,
        logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic signed [CW-1:0] pz,
        logic signed [CW-1:0] qx, logic signed [CW-1:0] qy, logic signed [CW-1:0] qz,
        logic signed [ANGLE_W-1:0] ang
    );
        longint      a;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      dx;
        longint      dy;
        longint      s;
        longint      c;
        longint      da;
        longint      db;
        longint      na;
        longint      nb;
        longint      half;
        longint      p [3];
        longint      q [3];
        bit          flip;
        bit          clipped;
        int          ia;
        int          ib;
        int          steps;
        rot_result_t r;

        p[0] = px;
        p[1] = py;
        p[2] = pz;
        q[0] = qx;
        q[1] = qy;
        q[2] = qz;
        flip = 1'b0;
        clipped = 1'b0;

        // Wrap into one turn, then fold into the right half plane.
        a = ang;
        if (a >= HALF_REV)
            a = a - FULL_REV;
        else if (a < -HALF_REV)
            a = a + FULL_REV;
        if (a > RIGHT_ANG)
        begin
            a = a - HALF_REV;
            flip = 1'b1;
        end
        else if (a < -RIGHT_ANG)
        begin
            a = a + HALF_REV;
            flip = 1'b1;
        end

        // Rotation-mode CORDIC with gain-compensated start vector.
        cx = GAIN_Q30;
        cy = 0;
        cz = a;
        steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - ARCTAN_DEG[i];
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + ARCTAN_DEG[i];
            end
        end
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        s = round_trig(cy);
        c = round_trig(cx);

        // Pick the in-plane pair for the chosen axis.
        case (op)
            OP_ROT_X:
            begin
                ia = 1;
                ib = 2;
            end
            OP_ROT_Y:
            begin
                ia = 2;
                ib = 0;
            end
            OP_ROT_Z:
            begin
                ia = 0;
                ib = 1;
            end
            default:
            begin
                ia = -1;
                ib = -1;
            end
        endcase

        if (ia >= 0)
        begin
            half = longint'(1) << (TRIG_FRAC - 1);
            da = p[ia] - q[ia];
            db = p[ib] - q[ib];
            na = ((c * da - s * db + half) >>> TRIG_FRAC) + q[ia];
            nb = ((s * da + c * db + half) >>> TRIG_FRAC) + q[ib];
            p[ia] = clamp_coord(na, clipped);
            p[ib] = clamp_coord(nb, clipped);
        end

        r.x = p[0][CW-1:0];
        r.y = p[1][CW-1:0];
        r.z = p[2][CW-1:0];
        r.ovf = clipped;
        return r;
    endfunction

    // Counts a failure and reports the first few of them.
    task automatic note_mismatch(string what, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t, %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Presents one item, waits for it to be taken and records its outcome.
    task automatic send_item(
        opcode_t op,
        logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic signed [CW-1:0] pz,
        logic signed [CW-1:0] qx, logic signed [CW-1:0] qy, logic signed [CW-1:0] qz,
        logic signed [ANGLE_W-1:0] ang,
        bit allow_gaps
    );
        start   <= 1'b1;
        opcode  <= op;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        pivot_x <= qx;
        pivot_y <= qy;
        pivot_z <= qz;
        angle   <= ang;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_rotations.push_back(predict_rotation(op, px, py, pz, qx, qy, qz, ang));

        // Occasionally leave the input idle for a few cycles.
        if (allow_gaps && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Mixture of full-range, small and near-extreme coordinates.
    function automatic logic signed [CW-1:0] rand_coord();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom);
            4, 5, 6:    v = int'($urandom_range(0, 2097152)) - 1048576;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = COORD_MAX;
                    1:       v = COORD_MIN;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            8:          v = COORD_MAX - int'($urandom_range(0, 65535));
            default:    v = COORD_MIN + int'($urandom_range(0, 65535));
        endcase
        return v[CW-1:0];
    endfunction

    // Mixture of any 26-bit angle, angles within a turn, near right angles and near zero.
    function automatic logic signed [ANGLE_W-1:0] rand_angle();
        int v;
        case ($urandom_range(0, 7))
            0, 1:       v = int'($urandom);
            2, 3, 4, 5: v = int'($urandom_range(0, 47185920)) - 23592960;
            6:          v = (int'($urandom_range(0, 8)) - 4) * 5898240
                            + int'($urandom_range(0, 4)) - 2;
            default:    v = int'($urandom_range(0, 200)) - 100;
        endcase
        return v[ANGLE_W-1:0];
    endfunction

    function automatic opcode_t rand_opcode();
        if ($urandom_range(0, 9) == 0)
            return OP_PASS;
        return opcode_t'($urandom_range(0, 2));
    endfunction

    // Known points, every axis, the pass opcode, angle boundaries and saturation.
    task automatic test_directed();
        send_item(OP_ROT_X, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, 0, 0, 0, 26'sd5898240, 1'b1);
        send_item(OP_ROT_Y, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, 0, 0, 0, -26'sd5898240, 1'b1);
        send_item(OP_ROT_Z, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, ONE_Q16, ONE_Q16, 0,
                  26'sd2949120, 1'b1);
        send_item(OP_PASS, COORD_MAX, COORD_MIN, -1, COORD_MIN, COORD_MAX, 0,
                  26'sd5898240, 1'b1);
        send_item(OP_ROT_Z, 5 * ONE_Q16, -7 * ONE_Q16, 9, 3, 4, 5, 26'sd0, 1'b1);
        // Exactly a half turn wraps to minus a half turn.
        send_item(OP_ROT_Z, 5 * ONE_Q16, -7 * ONE_Q16, 9, 0, 0, 0, 26'sd11796480, 1'b1);
        send_item(OP_ROT_X, 5, 5 * ONE_Q16, -7 * ONE_Q16, 0, 0, 0, -26'sd11796480, 1'b1);
        // Full turns either way.
        send_item(OP_ROT_Y, 3 * ONE_Q16, 0, -2 * ONE_Q16, 0, 0, 0, 26'sd23592960, 1'b1);
        send_item(OP_ROT_Y, 3 * ONE_Q16, 0, -2 * ONE_Q16, 0, 0, 0, -26'sd23592960, 1'b1);
        // Angles beyond a full turn, at the limits of the angle port.
        send_item(OP_ROT_Z, ONE_Q16, ONE_Q16, 0, 0, 0, 0, 26'sd33554431, 1'b1);
        send_item(OP_ROT_Z, ONE_Q16, ONE_Q16, 0, 0, 0, 0, -26'sd33554432, 1'b1);
        // Just past a right angle in either direction.
        send_item(OP_ROT_X, 0, ONE_Q16, ONE_Q16, 0, 0, 0, 26'sd5898241, 1'b1);
        send_item(OP_ROT_X, 0, ONE_Q16, ONE_Q16, 0, 0, 0, -26'sd5898241, 1'b1);
        // Widest possible offsets from the pivot, forcing saturation, and points on the pivot at the extremes.
        send_item(OP_ROT_Z, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                  26'sd11796480, 1'b1);
        send_item(OP_ROT_X, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                  26'sd11796480, 1'b1);
        send_item(OP_ROT_Y, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  26'sd5898240, 1'b1);
        send_item(OP_ROT_Y, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  26'sd17694720, 1'b1);
        send_item(OP_ROT_Z, -1, -1, -1, 0, 0, 0, 26'sd1, 1'b1);
        send_item(OP_ROT_Z, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 26'sd2949120, 1'b1);
        send_item(OP_ROT_Y, COORD_MIN, 0, COORD_MAX, 0, 0, 0, -26'sd2949120, 1'b1);
    endtask

    // Random items on every clock cycle.
    task automatic test_random_back_to_back(int count);
        for (int n = 0; n < count; n++)
            send_item(rand_opcode(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_angle(), 1'b0);
    endtask

    // Random items with idle cycles between them.
    task automatic test_random_with_gaps(int count);
        for (int n = 0; n < count; n++)
            send_item(rand_opcode(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_angle(), 1'b1);
    endtask

    // Compares every result with the oldest outstanding item.
    always @(posedge clk)
    begin : result_check
        rot_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_rotations.size() == 0)
                note_mismatch("result with no item outstanding", 0, 1);
            else
            begin
                want = pending_rotations.pop_front();
                if (rotated_x !== want.x)
                    note_mismatch("rotated_x", want.x, rotated_x);
                if (rotated_y !== want.y)
                    note_mismatch("rotated_y", want.y, rotated_y);
                if (rotated_z !== want.z)
                    note_mismatch("rotated_z", want.z, rotated_z);
                if (overflow !== want.ovf)
                    note_mismatch("overflow", want.ovf, overflow);
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_back_to_back(300);
        test_random_with_gaps(500);

        // Let the pipeline empty, then watch for stray results.
        start <= 1'b0;
        for (int n = 0; n < 1000 && pending_rotations.size() != 0; n++)
            @(posedge clk);
        repeat (2 * LATENCY + 10) @(posedge clk);
        if (pending_rotations.size() != 0)
            note_mismatch("items with no result", 0, pending_rotations.size());

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/prap_pkg.sv
design/prap_front.sv
design/prap_cell.sv
design/prap_rotate.sv
design/point_rotate_about_pivot_core.sv
design/prap_checker.sv
tb/point_rotate_about_pivot_core_tb.sv
